// File: rtl/gls_pkg.sv
package gls_pkg;

  localparam int MAX_MACHINES_DEF = 16;

  localparam int DUR_W  = 16;
  localparam int LOAD_W = 32;
  localparam int MACH_W = 4;
  localparam int ACT_W  = 5;

  localparam logic [ACT_W-1:0]  ACT_RESET = ACT_W'(16);
  localparam logic [LOAD_W-1:0] LOAD_MAX  = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // job beat accepted: latch job, clear on first job
    logic scan;    // read one load and step the scan index
    logic commit;  // add job, write load back, load result register
  } gls_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;   // scan index is on the last active machine
    logic can_commit;  // result register is free or being drained
  } gls_sts_t;

endpackage

// File: rtl/gls_intf.sv
interface gls_job_if;
  import gls_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] job_duration;
  logic             first_job;

  modport source (output valid, output job_duration, output first_job, input ready);
  modport sink   (input valid, input job_duration, input first_job, output ready);
endinterface

interface gls_res_if;
  import gls_pkg::*;

  logic              valid;
  logic              ready;
  logic [MACH_W-1:0] chosen_machine;
  logic [LOAD_W-1:0] new_load;
  logic [LOAD_W-1:0] makespan;
  logic              load_saturated;

  modport source (output valid, output chosen_machine, output new_load, output makespan,
                  output load_saturated, input ready);
  modport sink   (input valid, input chosen_machine, input new_load, input makespan,
                  input load_saturated, output ready);
endinterface

interface gls_cfg_if;
  import gls_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] active_machines;

  modport source (output valid, output active_machines, input ready);
  modport sink   (input valid, input active_machines, output ready);
endinterface

// File: rtl/gls_ctrl.sv
module gls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  gls_pkg::gls_sts_t  sts_i,
  output gls_pkg::gls_cmd_t  cmd_o
);
  import gls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   start;

  assign job_ready_o  = (state_q == ST_IDLE);
  assign start        = job_valid_i && job_ready_o;

  assign cmd_o.start  = start;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.commit = (state_q == ST_COMMIT) && sts_i.can_commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.scan_last) state_q <= ST_DRAIN;
        end
        // last read word is compared here
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        // hold until the result register is free
        ST_COMMIT: begin
          if (sts_i.can_commit) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/gls_dp.sv
module gls_dp #(
  parameter int MAX_MACHINES = gls_pkg::MAX_MACHINES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gls_pkg::gls_cmd_t          cmd_i,
  output gls_pkg::gls_sts_t          sts_o,
  input  logic [gls_pkg::DUR_W-1:0]  job_duration_i,
  input  logic                       first_job_i,
  input  logic                       cfg_valid_i,
  input  logic [gls_pkg::ACT_W-1:0]  cfg_active_machines_i,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output logic [gls_pkg::MACH_W-1:0] chosen_machine_o,
  output logic [gls_pkg::LOAD_W-1:0] new_load_o,
  output logic [gls_pkg::LOAD_W-1:0] makespan_o,
  output logic                       load_saturated_o
);
  import gls_pkg::*;

  localparam int IDX_W = $clog2(MAX_MACHINES);
  localparam int CNT_W = $clog2(MAX_MACHINES + 1);

  logic [LOAD_W-1:0] mem [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] vld_q;

  logic [ACT_W-1:0]  active_q;
  logic [DUR_W-1:0]  dur_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  rd_idx_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [LOAD_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [LOAD_W-1:0] cur_load;
  logic [IDX_W-1:0]  best_idx_q;
  logic [LOAD_W-1:0] best_load_q;
  logic [LOAD_W-1:0] mksp_q;

  logic [LOAD_W:0]   sum_wide;
  logic              sat;
  logic [LOAD_W-1:0] sum;
  logic [LOAD_W-1:0] mksp_d;

  logic              res_valid_q;
  logic [MACH_W-1:0] res_mach_q;
  logic [LOAD_W-1:0] res_load_q;
  logic [LOAD_W-1:0] res_mksp_q;
  logic              res_sat_q;

  // Zero active means one; clamp to the built count
  always_comb begin
    if (active_q == '0) begin
      n_d = CNT_W'(1);
    end else if (32'(active_q) > MAX_MACHINES) begin
      n_d = CNT_W'(MAX_MACHINES);
    end else begin
      n_d = CNT_W'(active_q);
    end
  end

  assign cur_load = rd_vld_q ? rd_data_q : '0;

  assign sum_wide = {1'b0, best_load_q} + {{(LOAD_W + 1 - DUR_W){1'b0}}, dur_q};
  assign sat      = sum_wide[LOAD_W];
  assign sum      = sat ? LOAD_MAX : sum_wide[LOAD_W-1:0];
  assign mksp_d   = (sum > mksp_q) ? sum : mksp_q;

  assign sts_o.scan_last  = (rd_idx_q == n_q - CNT_W'(1));
  assign sts_o.can_commit = !res_valid_q || res_ready_i;

  // Load store: one read, one write a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
    if (cmd_i.commit) begin
      mem[best_idx_q] <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      active_q    <= ACT_RESET;
      rd_idx_q    <= '0;
      n_q         <= CNT_W'(1);
      cmp_vld_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      mksp_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_active_machines_i;
      end
      cmp_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        rd_idx_q <= '0;
        n_q      <= n_d;
        if (first_job_i) begin
          vld_q  <= '0;
          mksp_q <= '0;
        end
      end
      if (cmd_i.scan) begin
        rd_vld_q <= vld_q[rd_idx_q[IDX_W-1:0]];
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (cmd_i.commit) begin
        vld_q[best_idx_q] <= 1'b1;
        mksp_q            <= mksp_d;
        res_valid_q       <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dur_q <= job_duration_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    // strict less-than keeps the lowest index on a tie
    if (cmp_vld_q && (cmp_idx_q == '0 || cur_load < best_load_q)) begin
      best_load_q <= cur_load;
      best_idx_q  <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      res_mach_q <= MACH_W'(best_idx_q);
      res_load_q <= sum;
      res_mksp_q <= mksp_d;
      res_sat_q  <= sat;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign chosen_machine_o = res_mach_q;
  assign new_load_o       = res_load_q;
  assign makespan_o       = res_mksp_q;
  assign load_saturated_o = res_sat_q;

endmodule

// File: rtl/greedy_list_scheduler_top.sv
// Greedy list scheduler: places each job on the least-loaded active machine.
//
// Channels: job_i takes one job beat (duration and first-job flag); res_o
// gives one result beat per job (machine, its new load, running makespan,
// saturation flag); cfg_i writes active_machines and is always ready.
// Write cfg_i only while no job is in flight.
//
// Sequence: with n active machines (clamped to 1..MAX_MACHINES) a job beat is
// followed by n load reads through the single read port of the load store,
// a compare of the last load and an update. The result beat appears once the
// update is done and job_i is ready again in the same cycle; no new job is
// taken while one is scanned or waits for its update.
//
// Reset: all loads and the makespan read as zero, active_machines is 16.
// Stall: the result waits in an output register; the next job is taken and
// scanned meanwhile, and its update holds until the register is drained.
module greedy_list_scheduler_top #(
  parameter int MAX_MACHINES = gls_pkg::MAX_MACHINES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  gls_job_if.sink   job_i,
  gls_cfg_if.sink   cfg_i,
  gls_res_if.source res_o
);
  import gls_pkg::*;

  gls_cmd_t cmd;
  gls_sts_t sts;

  assign cfg_i.ready = 1'b1;

  gls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_i.valid),
    .job_ready_o (job_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gls_dp #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .job_duration_i        (job_i.job_duration),
    .first_job_i           (job_i.first_job),
    .cfg_valid_i           (cfg_i.valid),
    .cfg_active_machines_i (cfg_i.active_machines),
    .res_ready_i           (res_o.ready),
    .res_valid_o           (res_o.valid),
    .chosen_machine_o      (res_o.chosen_machine),
    .new_load_o            (res_o.new_load),
    .makespan_o            (res_o.makespan),
    .load_saturated_o      (res_o.load_saturated)
  );

endmodule

// File: rtl/gls_chk.sv
module gls_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       job_valid_i,
  input logic                       job_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [gls_pkg::LOAD_W-1:0] new_load_i,
  input logic [gls_pkg::LOAD_W-1:0] makespan_i,
  input logic                       load_saturated_i
);
  import gls_pkg::*;

  // A waiting result beat is not withdrawn
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // The makespan covers the load just placed
  a_mksp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> new_load_i <= makespan_i)
    else $error("makespan below new load");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && load_saturated_i |-> new_load_i == LOAD_MAX)
    else $error("saturated load not at maximum");

  // No job beat is taken right after another: the scan is then running
  a_job_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_i |=> !job_ready_i)
    else $error("job taken during scan");

endmodule

bind greedy_list_scheduler_top gls_chk u_gls_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .job_valid_i      (job_i.valid),
  .job_ready_i      (job_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .new_load_i       (res_o.new_load),
  .makespan_i       (res_o.makespan),
  .load_saturated_i (res_o.load_saturated)
);

// File: bench/greedy_list_scheduler_top_test.sv
module greedy_list_scheduler_top_test;
  import gls_pkg::*;

  localparam int N_MACH         = MAX_MACHINES_DEF;
  localparam int RANDOM_JOBS    = 1300;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int IDLE_PCT       = 31;

  typedef struct {
    logic [MACH_W-1:0] machine;
    logic [LOAD_W-1:0] load;
    logic [LOAD_W-1:0] span;
    logic              sat;
  } placement_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gls_job_if job_if ();
  gls_cfg_if cfg_if ();
  gls_res_if res_if ();

  greedy_list_scheduler_top #(
    .MAX_MACHINES(N_MACH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .job_i (job_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Scheduler state as the testbench sees it
  logic [LOAD_W-1:0] load_mdl [N_MACH];
  logic [LOAD_W-1:0] span_mdl;
  logic [ACT_W-1:0]  active_cfg;

  placement_t  placement_q [$];
  int unsigned mismatches = 0;
  int unsigned jobs_sent  = 0;
  bit          idle_en    = 1'b1;
  logic        rx_hold    = 1'b0;
  event        rx_stall_ev;

  function automatic placement_t place_job(input logic [DUR_W-1:0] dur, input logic first);
    placement_t        p;
    int unsigned       n;
    int unsigned       best;
    logic [LOAD_W:0]   sum;
    if (first) begin
      foreach (load_mdl[k]) load_mdl[k] = '0;
      span_mdl = '0;
    end
    n = (active_cfg == 0) ? 1 : ((active_cfg > N_MACH) ? N_MACH : active_cfg);
    best = 0;
    for (int unsigned k = 1; k < n; k++) begin
      if (load_mdl[k] < load_mdl[best]) best = k;
    end
    sum = {1'b0, load_mdl[best]} + dur;
    p.sat = sum[LOAD_W];
    load_mdl[best] = p.sat ? LOAD_MAX : sum[LOAD_W-1:0];
    if (load_mdl[best] > span_mdl) span_mdl = load_mdl[best];
    p.machine = MACH_W'(best);
    p.load    = load_mdl[best];
    p.span    = span_mdl;
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [LOAD_W-1:0] exp_v,
                                      input logic [LOAD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  // Result side: check the beat taken at this edge, then pick the next ready
  always @(posedge clk_i) begin : rx_side
    placement_t exp_p;
    if (res_if.valid && res_if.ready) begin
      if (placement_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: machine %0d load %0h",
                   res_if.chosen_machine, res_if.new_load);
      end else begin
        exp_p = placement_q.pop_front();
        check_field("chosen_machine", LOAD_W'(exp_p.machine), LOAD_W'(res_if.chosen_machine));
        check_field("new_load", exp_p.load, res_if.new_load);
        check_field("makespan", exp_p.span, res_if.makespan);
        check_field("load_saturated", LOAD_W'(exp_p.sat), LOAD_W'(res_if.load_saturated));
      end
    end
    res_if.ready <= !rx_hold && !(idle_en && $urandom_range(99) < IDLE_PCT);
  end

  // Long receiver hold-off, so the block fills up and stalls the job side
  initial begin
    forever begin
      @(rx_stall_ev);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  task automatic send_job(input logic [DUR_W-1:0] dur, input logic first);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      job_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    job_if.valid        <= 1'b1;
    job_if.job_duration <= dur;
    job_if.first_job    <= first;
    @(posedge clk_i);
    while (!job_if.ready) @(posedge clk_i);
    placement_q = {placement_q, place_job(dur, first)};
    jobs_sent++;
  endtask

  task automatic drain_results();
    job_if.valid <= 1'b0;
    do @(posedge clk_i); while (placement_q.size() != 0);
  endtask

  // Write the register only once every result is back
  task automatic set_active(input logic [ACT_W-1:0] val);
    drain_results();
    cfg_if.valid           <= 1'b1;
    cfg_if.active_machines <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    active_cfg = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ACT_W-1:0] pick_active();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return ACT_W'(1);
    if (r < 50) return ACT_W'(16);
    if (r < 60) return ACT_W'(0);
    if (r < 70) return ACT_W'($urandom_range(31, 17));
    return ACT_W'($urandom_range(15, 2));
  endfunction

  // Reset value of the register, ties on empty machines, mid-stream clear
  task automatic test_reset_defaults();
    send_job(16'hFFFF, 1'b1);
    send_job(16'h0000, 1'b0);
    send_job(16'h0001, 1'b0);
    send_job(16'h8000, 1'b0);
    send_job(16'h0000, 1'b1);
  endtask

  task automatic test_active_extremes();
    set_active(ACT_W'(0));
    send_job(16'd7, 1'b1);
    send_job(16'd9, 1'b0);
    send_job(16'hFFFF, 1'b0);
    set_active(ACT_W'(31));
    send_job(16'd3, 1'b1);
    send_job(16'd3, 1'b0);
    set_active(ACT_W'(17));
    send_job(16'd2, 1'b0);
  endtask

  // Machines dropped from the scan keep their loads and the makespan
  task automatic test_shrink_active();
    set_active(ACT_W'(4));
    send_job(16'd10, 1'b1);
    send_job(16'd90, 1'b0);
    send_job(16'd30, 1'b0);
    set_active(ACT_W'(1));
    send_job(16'd5, 1'b0);
    set_active(ACT_W'(3));
    send_job(16'd20, 1'b0);
    set_active(ACT_W'(2));
    send_job(16'd100, 1'b0);
  endtask

  // One machine taking a run of full-length jobs back to back
  task automatic test_single_machine();
    idle_en = 1'b0;
    set_active(ACT_W'(1));
    for (int i = 0; i < 40; i++) send_job(16'hFFFF, i == 0);
    send_job(16'h0000, 1'b0);
    send_job(16'h0001, 1'b0);
    send_job(16'h0004, 1'b1);
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    set_active(ACT_W'(2));
    -> rx_stall_ev;
    for (int i = 0; i < 40; i++) send_job(DUR_W'($urandom), i == 0);
    idle_en = 1'b1;
  endtask

  // Mostly sorted instances with random content, some unsorted noise
  task automatic test_random_instances();
    int unsigned      base;
    int unsigned      len;
    logic [DUR_W-1:0] dur;
    logic             first;
    bit               sorted;
    base = jobs_sent;
    while (jobs_sent - base < RANDOM_JOBS) begin
      idle_en = !((jobs_sent - base) >= 500 && (jobs_sent - base) < 800);
      set_active(pick_active());
      sorted = $urandom_range(99) < 85;
      len    = $urandom_range(40, 1);
      dur    = DUR_W'($urandom);
      for (int unsigned i = 0; i < len; i++) begin
        first = sorted ? (i == 0) : ($urandom_range(99) < 10);
        send_job(dur, first);
        if (!sorted) dur = DUR_W'($urandom);
        else if ($urandom_range(3) != 0) dur = dur - DUR_W'($urandom_range(dur >> 2, 0));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    job_if.valid           = 1'b0;
    job_if.job_duration    = '0;
    job_if.first_job       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.active_machines = '0;
    res_if.ready           = 1'b0;
    foreach (load_mdl[k]) load_mdl[k] = '0;
    span_mdl   = '0;
    active_cfg = ACT_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_active_extremes();
    test_shrink_active();
    test_single_machine();
    test_backpressure();
    test_random_instances();

    drain_results();
    repeat (2 * N_MACH + 8) @(posedge clk_i);
    if (mismatches == 0 && placement_q.size() == 0) begin
      $display("PASS greedy_list_scheduler_top");
    end else begin
      $display("FAIL greedy_list_scheduler_top");
    end
    $finish;
  end

  initial begin
    #(4 * 4_000_000);
    $display("FAIL greedy_list_scheduler_top");
    $finish;
  end

endmodule
